// ===== hw/rtl/isc_pkg.sv =====
`default_nettype none

package isc_pkg;

    typedef enum logic [12:0] {
        M_NORMAL     = 13'b0000000000001,
        M_N_SLASH    = 13'b0000000000010,
        M_LINE       = 13'b0000000000100,
        M_BLOCK      = 13'b0000000001000,
        M_BLOCK_STAR = 13'b0000000010000,
        M_LITERAL    = 13'b0000000100000,
        M_LIT_ESC    = 13'b0000001000000,
        M_DT_SPACE   = 13'b0000010000000,
        M_DT_SLASH   = 13'b0000100000000,
        M_DT_COMMENT = 13'b0001000000000,
        M_DT_STAR    = 13'b0010000000000,
        M_KEYWORD    = 13'b0100000000000,
        M_PATH       = 13'b1000000000000
    } t_mode;

    typedef enum logic [1:0] {
        KIND_PATH    = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_ABANDON = 2'd2
    } t_kind;

    typedef struct packed {
        t_mode       mode;
        logic        line_start;
        logic [2:0]  kw_pos;
        logic        closer;
        logic        angle;
        logic [15:0] count;
    } t_scan_state;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ch;
        logic        angle;
        logic [15:0] len;
    } t_result;

    // one input beat worth of results; pair set when res1 is used too
    typedef struct packed {
        logic    pair;
        t_result res0;
        t_result res1;
    } t_record;

    typedef struct packed {
        logic    valid;
        t_record rec;
    } t_queue_wr;

    typedef struct packed {
        t_scan_state st;
        logic        redo;
        logic        emit;
        t_kind       kind;
        logic [7:0]  ch;
    } t_pass;

    localparam int SCAN_PASSES = 6;
    localparam logic [2:0] KW_LEN = 3'd7;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    localparam t_scan_state SCAN_RESET = '{
        mode: M_NORMAL, line_start: 1'b1, kw_pos: 3'd0,
        closer: 1'b0, angle: 1'b0, count: 16'd0
    };

    function automatic logic is_hspace(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CH_USCORE;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] p);
        logic [7:0] ch;
        unique case (p)
            3'd0:    ch = 8'h69;
            3'd1:    ch = 8'h6E;
            3'd2:    ch = 8'h63;
            3'd3:    ch = 8'h6C;
            3'd4:    ch = 8'h75;
            3'd5:    ch = 8'h64;
            3'd6:    ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic t_pass scan_pass(input t_scan_state s, input logic [7:0] c);
        t_pass r;
        r.st   = s;
        r.redo = 1'b0;
        r.emit = 1'b0;
        r.kind = KIND_PATH;
        r.ch   = 8'd0;
        unique case (s.mode)
            M_N_SLASH: begin
                if (c == CH_SLASH) begin
                    r.st.mode = M_LINE;
                end else if (c == CH_STAR) begin
                    r.st.mode = M_BLOCK;
                end else begin
                    r.st.line_start = 1'b0;
                    r.st.mode = M_NORMAL;
                    r.redo = 1'b1;
                end
            end
            M_LINE: begin
                if (c == CH_NL) begin
                    r.st.line_start = 1'b1;
                    r.st.mode = M_NORMAL;
                end
            end
            M_BLOCK: begin
                if (c == CH_NL) begin
                    r.st.line_start = 1'b1;
                end else if (c == CH_STAR) begin
                    r.st.mode = M_BLOCK_STAR;
                end
            end
            M_BLOCK_STAR: begin
                if (c == CH_SLASH) begin
                    r.st.mode = M_NORMAL;
                end else if (c == CH_NL) begin
                    r.st.line_start = 1'b1;
                    r.st.mode = M_BLOCK;
                end else if (c != CH_STAR) begin
                    r.st.mode = M_BLOCK;
                end
            end
            M_LITERAL: begin
                if (c == CH_BSLASH) begin
                    r.st.mode = M_LIT_ESC;
                end else if (c == (s.closer ? CH_APOS : CH_QUOTE)) begin
                    r.st.mode = M_NORMAL;
                end
            end
            M_LIT_ESC: begin
                r.st.mode = M_LITERAL;
            end
            M_DT_SPACE: begin
                if (is_hspace(c)) begin
                    r.st.mode = M_DT_SPACE;
                end else if (c == CH_SLASH) begin
                    r.st.mode = M_DT_SLASH;
                end else if (s.kw_pos == 3'd0 && c == kw_char(3'd0)) begin
                    r.st.kw_pos = 3'd1;
                    r.st.mode = M_KEYWORD;
                end else if (s.kw_pos == KW_LEN && (c == CH_QUOTE || c == CH_LT)) begin
                    r.st.angle = (c == CH_LT);
                    r.st.count = 16'd0;
                    r.st.mode = M_PATH;
                end else begin
                    r.st.mode = M_NORMAL;
                    r.redo = 1'b1;
                end
            end
            M_DT_SLASH: begin
                if (c == CH_STAR) begin
                    r.st.mode = M_DT_COMMENT;
                end else begin
                    r.st.mode = M_N_SLASH;
                    r.redo = 1'b1;
                end
            end
            M_DT_COMMENT, M_DT_STAR: begin
                if (c == CH_NL) begin
                    r.st.line_start = 1'b1;
                    r.st.mode = M_BLOCK;
                end else if (s.mode == M_DT_STAR && c == CH_SLASH) begin
                    r.st.mode = M_DT_SPACE;
                end else begin
                    r.st.mode = (c == CH_STAR) ? M_DT_STAR : M_DT_COMMENT;
                end
            end
            M_KEYWORD: begin
                if (s.kw_pos < KW_LEN) begin
                    if (c == kw_char(s.kw_pos)) begin
                        r.st.kw_pos = s.kw_pos + 3'd1;
                    end else begin
                        r.st.mode = M_NORMAL;
                        r.redo = 1'b1;
                    end
                end else if (is_ident(c)) begin
                    r.st.mode = M_NORMAL;
                    r.redo = 1'b1;
                end else begin
                    r.st.mode = M_DT_SPACE;
                    r.redo = 1'b1;
                end
            end
            M_PATH: begin
                if (c == (s.angle ? CH_GT : CH_QUOTE)) begin
                    r.emit = 1'b1;
                    r.st.mode = M_NORMAL;
                    // empty path: closer is rescanned as ordinary text
                    if (s.count == 16'd0) begin
                        r.kind = KIND_ABANDON;
                        r.redo = 1'b1;
                    end else begin
                        r.kind = KIND_DONE;
                    end
                end else if (c == CH_NL) begin
                    r.emit = 1'b1;
                    r.kind = KIND_ABANDON;
                    r.st.mode = M_NORMAL;
                    r.redo = 1'b1;
                end else begin
                    if (s.count != COUNT_MAX) begin
                        r.st.count = s.count + 16'd1;
                    end
                    r.emit = 1'b1;
                    r.kind = KIND_PATH;
                    r.ch = c;
                end
            end
            default: begin
                r.st.mode = M_NORMAL;
                if (is_hspace(c)) begin
                    r.st.mode = M_NORMAL;
                end else if (c == CH_NL) begin
                    r.st.line_start = 1'b1;
                end else if (c == CH_SLASH) begin
                    r.st.mode = M_N_SLASH;
                end else if (c == CH_HASH && s.line_start) begin
                    r.st.line_start = 1'b0;
                    r.st.kw_pos = 3'd0;
                    r.st.mode = M_DT_SPACE;
                end else if (c == CH_QUOTE || c == CH_APOS) begin
                    r.st.line_start = 1'b0;
                    r.st.closer = (c == CH_APOS);
                    r.st.mode = M_LITERAL;
                end else begin
                    r.st.line_start = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/include_directive_scanner_core.sv =====
// Include directive scanner.
// Input side is a queue write port: a source beat (i_text_byte, i_end_of_text)
// is taken at a rising edge with push high and full low. i_end_of_text marks
// the last byte of a text and returns the scanner to its start state.
// Output side is a queue read port: while empty is low the oldest result is on
// o_result_kind/o_path_char/o_angle_form/o_path_length/o_last_of_run; it is
// taken at an edge with pop high. Each byte yields zero, one or two results.
// Throughput: one byte per cycle on input while full is low; the scanner state
// update is combinational. Output drains one result per cycle while pop is high,
// so a run of bytes with two results each holds the input back once the queue fills.
// A byte is scanned into the record queue at the edge that takes it, and when
// queue and output register are empty its first result moves to the output
// register at the next edge, where it is visible on the outputs.
// The record queue holds QUEUE_DEPTH beats of results; when pop is held low
// the output register holds, the queue fills and full rises, stalling the
// source without losing scanner state.
// Reset (synchronous, active low) empties the queue and output register and
// returns the scanner to normal mode at line start.
`default_nettype none

module include_directive_scanner_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_end_of_text,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_result_kind,
    output logic [7:0]       o_path_char,
    output logic             o_angle_form,
    output logic [15:0]      o_path_length,
    output logic             o_last_of_run
);
    import isc_pkg::*;

    t_queue_wr wr;
    t_record   head;
    t_result   res;
    logic      head_valid;
    logic      rd;
    logic      accept;

    assign accept = push && !full;

    isc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_text_byte  (i_text_byte),
        .i_end_of_text(i_end_of_text),
        .o_wr         (wr)
    );

    isc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .o_full      (full),
        .o_head      (head),
        .o_head_valid(head_valid),
        .i_rd        (rd)
    );

    isc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_head_valid(head_valid),
        .o_rd        (rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res),
        .o_last      (o_last_of_run)
    );

    assign o_result_kind = res.kind;
    assign o_path_char   = res.ch;
    assign o_angle_form  = res.angle;
    assign o_path_length = res.len;

endmodule

`default_nettype wire

// ===== hw/rtl/isc_front.sv =====
`default_nettype none

module isc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_text_byte,
    input  wire logic              i_end_of_text,
    output isc_pkg::t_queue_wr     o_wr
);
    import isc_pkg::*;

    t_scan_state r_scan;
    t_scan_state n_scan;
    t_scan_state s;
    t_pass       p;
    t_record     rec;
    logic [1:0]  n;
    logic        go;

    always_comb begin
        s   = r_scan;
        p   = '0;
        rec = '0;
        n   = 2'd0;
        go  = 1'b1;
        for (int i = 0; i < SCAN_PASSES; i++) begin
            if (go) begin
                p  = scan_pass(s, i_text_byte);
                s  = p.st;
                go = p.redo;
                if (p.emit) begin
                    if (n == 2'd0) begin
                        rec.res0 = '{kind: p.kind, ch: p.ch, angle: s.angle, len: s.count};
                        n = 2'd1;
                    end else if (n == 2'd1) begin
                        rec.res1 = '{kind: p.kind, ch: p.ch, angle: s.angle, len: s.count};
                        n = 2'd2;
                    end
                end
            end
        end
        if (i_end_of_text) begin
            // text ends inside a path
            if (s.mode == M_PATH) begin
                if (n == 2'd0) begin
                    rec.res0 = '{kind: KIND_ABANDON, ch: 8'd0, angle: s.angle, len: s.count};
                    n = 2'd1;
                end else if (n == 2'd1) begin
                    rec.res1 = '{kind: KIND_ABANDON, ch: 8'd0, angle: s.angle, len: s.count};
                    n = 2'd2;
                end
            end
            s = SCAN_RESET;
        end
        rec.pair   = (n == 2'd2);
        n_scan     = s;
        o_wr.valid = i_accept && (n != 2'd0);
        o_wr.rec   = rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= SCAN_RESET;
        end else if (i_accept) begin
            r_scan <= n_scan;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/isc_queue.sv =====
`default_nettype none

module isc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  isc_pkg::t_queue_wr     i_wr,
    output logic                   o_full,
    output isc_pkg::t_record       o_head,
    output logic                   o_head_valid,
    input  wire logic              i_rd
);
    import isc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_record       r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr_en;
    logic          rd_en;

    assign o_full       = (r_count == CNT_FULL);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign wr_en        = i_wr.valid && !o_full;
    assign rd_en        = i_rd && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/isc_back.sv =====
`default_nettype none

module isc_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  isc_pkg::t_record       i_head,
    input  wire logic              i_head_valid,
    output logic                   o_rd,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output isc_pkg::t_result       o_res,
    output logic                   o_last
);
    import isc_pkg::*;

    logic    r_valid;
    logic    r_sel;
    t_result r_res;
    logic    r_last;
    t_result head_res;
    logic    head_last;
    logic    load;

    assign head_res  = r_sel ? i_head.res1 : i_head.res0;
    assign head_last = !i_head.pair || r_sel;
    assign load      = !r_valid || i_pop;
    assign o_rd      = load && i_head_valid && head_last;
    assign o_empty   = !r_valid;
    assign o_res     = r_res;
    assign o_last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (load) begin
            r_valid <= i_head_valid;
            if (i_head_valid) begin
                r_sel <= !head_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_head_valid) begin
            r_res  <= head_res;
            r_last <= head_last;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/isc_checker.sv =====
`default_nettype none

module isc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [1:0]  o_result_kind,
    input wire logic [7:0]  o_path_char,
    input wire logic        o_angle_form,
    input wire logic [15:0] o_path_length,
    input wire logic        o_last_of_run
);
    import isc_pkg::*;

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result visible right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result_kind) && $stable(o_path_char)
            && $stable(o_angle_form) && $stable(o_path_length) && $stable(o_last_of_run))
        else $error("stalled result beat changed");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_result_kind == KIND_PATH || o_result_kind == KIND_DONE
            || o_result_kind == KIND_ABANDON)
        else $error("illegal result kind");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result_kind != KIND_PATH |-> o_last_of_run)
        else $error("marker not last of run");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_result_kind == KIND_PATH || o_result_kind == KIND_DONE)
            |-> o_path_length != 16'd0)
        else $error("path byte or complete marker with zero length");

endmodule

bind include_directive_scanner_core isc_checker u_isc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_result_kind(o_result_kind),
    .o_path_char  (o_path_char),
    .o_angle_form (o_angle_form),
    .o_path_length(o_path_length),
    .o_last_of_run(o_last_of_run)
);

`default_nettype wire

// ===== dv/include_scan_checker.sv =====
module include_scan_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic        i_full,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_end_of_text,
    input  wire logic        i_empty,
    input  wire logic        i_pop,
    input  wire logic [1:0]  i_result_kind,
    input  wire logic [7:0]  i_path_char,
    input  wire logic        i_angle_form,
    input  wire logic [15:0] i_path_length,
    input  wire logic        i_last_of_run,
    output int               o_fail_count,
    output int               o_outstanding
);
    import isc_pkg::*;

    localparam logic [55:0] KEYWORD_TEXT = "include";
    localparam int MAX_PASSES = 6;
    localparam int MAX_PER_BYTE = 2;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  ch;
        logic        angle;
        logic [15:0] len;
        logic        run_end;
    } t_scan_result;

    t_mode       scan_mode;
    logic        at_line_start;
    logic [2:0]  kw_idx;
    logic        apos_closer;
    logic        angle_path;
    logic [15:0] path_len;

    t_scan_result expected_results[$];
    int           fail_total = 0;

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF};
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == CH_USCORE;
    endfunction

    function automatic logic [7:0] keyword_char(input logic [2:0] idx);
        return KEYWORD_TEXT[8 * (6 - int'(idx)) +: 8];
    endfunction

    function automatic t_scan_result marker(input t_kind kind, input logic [7:0] ch);
        t_scan_result r;
        r.kind    = kind;
        r.ch      = ch;
        r.angle   = angle_path;
        r.len     = path_len;
        r.run_end = 1'b0;
        return r;
    endfunction

    task automatic reset_scanner();
        scan_mode     = M_NORMAL;
        at_line_start = 1'b1;
        kw_idx        = 3'd0;
        apos_closer   = 1'b0;
        angle_path    = 1'b0;
        path_len      = 16'd0;
    endtask

    task automatic predict_byte(input logic [7:0] c, input logic eot);
        t_scan_result produced[$];
        logic         rescan;
        int           pass_no;
        rescan  = 1'b1;
        pass_no = 0;
        while (rescan && pass_no < MAX_PASSES) begin
            rescan = 1'b0;
            pass_no++;
            case (scan_mode)
                M_N_SLASH: begin
                    if (c == CH_SLASH) begin
                        scan_mode = M_LINE;
                    end else if (c == CH_STAR) begin
                        scan_mode = M_BLOCK;
                    end else begin
                        at_line_start = 1'b0;
                        scan_mode = M_NORMAL;
                        rescan = 1'b1;
                    end
                end
                M_LINE: begin
                    if (c == CH_NL) begin
                        at_line_start = 1'b1;
                        scan_mode = M_NORMAL;
                    end
                end
                M_BLOCK: begin
                    if (c == CH_NL) at_line_start = 1'b1;
                    else if (c == CH_STAR) scan_mode = M_BLOCK_STAR;
                end
                M_BLOCK_STAR: begin
                    if (c == CH_SLASH) begin
                        scan_mode = M_NORMAL;
                    end else if (c == CH_NL) begin
                        at_line_start = 1'b1;
                        scan_mode = M_BLOCK;
                    end else if (c != CH_STAR) begin
                        scan_mode = M_BLOCK;
                    end
                end
                M_LITERAL: begin
                    if (c == CH_BSLASH) scan_mode = M_LIT_ESC;
                    else if (c == (apos_closer ? CH_APOS : CH_QUOTE)) scan_mode = M_NORMAL;
                end
                M_LIT_ESC: scan_mode = M_LITERAL;
                M_DT_SPACE: begin
                    if (is_blank(c)) begin
                    end else if (c == CH_SLASH) begin
                        scan_mode = M_DT_SLASH;
                    end else if (kw_idx == 3'd0 && c == keyword_char(3'd0)) begin
                        kw_idx = 3'd1;
                        scan_mode = M_KEYWORD;
                    end else if (kw_idx == 3'd7 && (c == CH_QUOTE || c == CH_LT)) begin
                        angle_path = (c == CH_LT);
                        path_len = 16'd0;
                        scan_mode = M_PATH;
                    end else begin
                        scan_mode = M_NORMAL;
                        rescan = 1'b1;
                    end
                end
                M_DT_SLASH: begin
                    if (c == CH_STAR) begin
                        scan_mode = M_DT_COMMENT;
                    end else begin
                        scan_mode = M_N_SLASH;
                        rescan = 1'b1;
                    end
                end
                M_DT_COMMENT, M_DT_STAR: begin
                    if (c == CH_NL) begin
                        at_line_start = 1'b1;
                        scan_mode = M_BLOCK;
                    end else if (scan_mode == M_DT_STAR && c == CH_SLASH) begin
                        scan_mode = M_DT_SPACE;
                    end else begin
                        scan_mode = (c == CH_STAR) ? M_DT_STAR : M_DT_COMMENT;
                    end
                end
                M_KEYWORD: begin
                    if (kw_idx < 3'd7) begin
                        if (c == keyword_char(kw_idx)) begin
                            kw_idx = kw_idx + 3'd1;
                        end else begin
                            scan_mode = M_NORMAL;
                            rescan = 1'b1;
                        end
                    end else begin
                        scan_mode = is_word_char(c) ? M_NORMAL : M_DT_SPACE;
                        rescan = 1'b1;
                    end
                end
                M_PATH: begin
                    if (c == (angle_path ? CH_GT : CH_QUOTE)) begin
                        scan_mode = M_NORMAL;
                        if (path_len == 16'd0) begin
                            // empty path, closer goes back through normal scan
                            if (produced.size() < MAX_PER_BYTE)
                                produced.push_back(marker(KIND_ABANDON, 8'd0));
                            rescan = 1'b1;
                        end else if (produced.size() < MAX_PER_BYTE) begin
                            produced.push_back(marker(KIND_DONE, 8'd0));
                        end
                    end else if (c == CH_NL) begin
                        if (produced.size() < MAX_PER_BYTE)
                            produced.push_back(marker(KIND_ABANDON, 8'd0));
                        scan_mode = M_NORMAL;
                        rescan = 1'b1;
                    end else begin
                        if (path_len != 16'hFFFF) path_len = path_len + 16'd1;
                        if (produced.size() < MAX_PER_BYTE)
                            produced.push_back(marker(KIND_PATH, c));
                    end
                end
                default: begin
                    scan_mode = M_NORMAL;
                    if (is_blank(c)) begin
                    end else if (c == CH_NL) begin
                        at_line_start = 1'b1;
                    end else if (c == CH_SLASH) begin
                        scan_mode = M_N_SLASH;
                    end else if (c == CH_HASH && at_line_start) begin
                        at_line_start = 1'b0;
                        kw_idx = 3'd0;
                        scan_mode = M_DT_SPACE;
                    end else if (c == CH_QUOTE || c == CH_APOS) begin
                        at_line_start = 1'b0;
                        apos_closer = (c == CH_APOS);
                        scan_mode = M_LITERAL;
                    end else begin
                        at_line_start = 1'b0;
                    end
                end
            endcase
        end
        if (eot) begin
            if (scan_mode == M_PATH && produced.size() < MAX_PER_BYTE)
                produced.push_back(marker(KIND_ABANDON, 8'd0));
            reset_scanner();
        end
        if (produced.size() > 0) produced[produced.size() - 1].run_end = 1'b1;
        foreach (produced[i]) expected_results.push_back(produced[i]);
    endtask

    task automatic check_result();
        t_scan_result want;
        if (expected_results.size() == 0) begin
            $error("unexpected result: kind %0d char %0d length %0d",
                   i_result_kind, i_path_char, i_path_length);
            fail_total++;
        end else begin
            want = expected_results.pop_front();
            if (i_result_kind !== want.kind) begin
                $error("result_kind: expected %0d, actual %0d", want.kind, i_result_kind);
                fail_total++;
            end
            if (i_path_char !== want.ch) begin
                $error("path_char: expected %0d, actual %0d", want.ch, i_path_char);
                fail_total++;
            end
            if (i_angle_form !== want.angle) begin
                $error("angle_form: expected %0d, actual %0d", want.angle, i_angle_form);
                fail_total++;
            end
            if (i_path_length !== want.len) begin
                $error("path_length: expected %0d, actual %0d", want.len, i_path_length);
                fail_total++;
            end
            if (i_last_of_run !== want.run_end) begin
                $error("last_of_run: expected %0d, actual %0d", want.run_end, i_last_of_run);
                fail_total++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_scanner();
            expected_results.delete();
        end else begin
            if (i_push && !i_full) predict_byte(i_text_byte, i_end_of_text);
            if (i_pop && !i_empty) check_result();
        end
        o_outstanding <= expected_results.size();
        o_fail_count  <= fail_total;
    end

endmodule

// ===== dv/include_directive_scanner_core_tb.sv =====
module include_directive_scanner_core_tb;

    import isc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int BYTES_PER_PHASE = 340;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_text_byte = 8'd0;
    logic        i_end_of_text = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_path_char;
    logic        o_angle_form;
    logic [15:0] o_path_length;
    logic        o_last_of_run;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int bytes_sent = 0;

    logic [7:0] text_buf[$];

    include_directive_scanner_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .empty         (empty),
        .pop           (pop),
        .o_result_kind (o_result_kind),
        .o_path_char   (o_path_char),
        .o_angle_form  (o_angle_form),
        .o_path_length (o_path_length),
        .o_last_of_run (o_last_of_run)
    );

    include_scan_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_result_kind (o_result_kind),
        .i_path_char   (o_path_char),
        .i_angle_form  (o_angle_form),
        .i_path_length (o_path_length),
        .i_last_of_run (o_last_of_run),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (full);
        bytes_sent++;
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    task automatic flush_text(input logic eot_last);
        logic [7:0] b;
        while (text_buf.size() > 0) begin
            b = text_buf.pop_front();
            send_byte(b, eot_last && text_buf.size() == 0);
        end
    endtask

    function automatic logic [7:0] rand_letter();
        return 8'(int'("a") + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 4))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            3: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    // path or comment byte, steering clear of the given stop bytes
    function automatic logic [7:0] rand_body(input logic [7:0] stop_a, input logic [7:0] stop_b);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == stop_a || b == stop_b) b = rand_letter();
        return b;
    endfunction

    task automatic put_gap();
        int n;
        n = $urandom_range(0, 2);
        repeat (n) text_buf.push_back(rand_blank());
        if ($urandom_range(0, 3) == 0) begin
            put_str("/*");
            repeat ($urandom_range(0, 3)) text_buf.push_back(rand_body(CH_NL, CH_SLASH));
            if ($urandom_range(0, 5) == 0) text_buf.push_back(CH_NL);
            put_str("*/");
            repeat ($urandom_range(0, 1)) text_buf.push_back(rand_blank());
        end
    endtask

    task automatic put_directive();
        string       kw;
        logic        angle;
        logic [7:0]  closer;
        int          n;
        kw = "include";
        if ($urandom_range(0, 3) == 0) put_gap();
        text_buf.push_back(CH_HASH);
        put_gap();
        if ($urandom_range(0, 9) == 0) kw[$urandom_range(0, 6)] = rand_letter();
        if ($urandom_range(0, 11) == 0) kw = kw.substr(0, $urandom_range(0, 5));
        put_str(kw);
        if ($urandom_range(0, 11) == 0) text_buf.push_back(rand_letter());
        put_gap();
        angle  = $urandom_range(0, 1);
        closer = angle ? CH_GT : CH_QUOTE;
        text_buf.push_back(angle ? CH_LT : CH_QUOTE);
        n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
        repeat (n) text_buf.push_back(rand_body(closer, CH_NL));
        if ($urandom_range(0, 9) == 0) text_buf.push_back(CH_NL);
        if ($urandom_range(0, 9) != 0) text_buf.push_back(closer);
        if ($urandom_range(0, 3) == 0) put_str(" x");
        text_buf.push_back(CH_NL);
    endtask

    task automatic put_other();
        case ($urandom_range(0, 4))
            0: begin
                put_str("// ");
                repeat ($urandom_range(0, 4)) text_buf.push_back(rand_body(CH_NL, CH_NL));
                text_buf.push_back(CH_NL);
            end
            1: begin
                put_str("/*");
                repeat ($urandom_range(0, 6)) begin
                    case ($urandom_range(0, 3))
                        0: text_buf.push_back(CH_STAR);
                        1: text_buf.push_back(CH_NL);
                        default: text_buf.push_back(rand_letter());
                    endcase
                end
                put_str("*/\n");
            end
            2: begin
                text_buf.push_back($urandom_range(0, 1) ? CH_APOS : CH_QUOTE);
                repeat ($urandom_range(0, 5)) begin
                    case ($urandom_range(0, 4))
                        0: text_buf.push_back(CH_BSLASH);
                        1: text_buf.push_back(CH_QUOTE);
                        2: text_buf.push_back(CH_APOS);
                        default: text_buf.push_back(rand_letter());
                    endcase
                end
                text_buf.push_back(CH_APOS);
                text_buf.push_back(CH_QUOTE);
                text_buf.push_back(CH_NL);
            end
            3: begin
                text_buf.push_back(CH_HASH);
                put_str("/* ");
                text_buf.push_back(CH_NL);
                put_str("*/#include\"z\"\n");
            end
            default: begin
                repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic run_random(input int target);
        while (bytes_sent < target) begin
            if ($urandom_range(0, 99) < 65) put_directive();
            else put_other();
            flush_text($urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 32;
        rx_idle_pct = 80;
        put_str("#include\"a\"\n");
        flush_text(1'b0);
        put_str("#include<>");
        flush_text(1'b1);
        put_str("#include<");
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h00);
        flush_text(1'b1);
        run_random(BYTES_PER_PHASE);

        tx_idle_pct = 80;
        rx_idle_pct = 32;
        run_random(2 * BYTES_PER_PHASE);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(3 * BYTES_PER_PHASE);

        push <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
